/* design/medt_pkg.sv */
package medt_pkg;

   // edge store geometry
   localparam int MAX_EDGES = 1024;
   localparam int SLOT_W    = $clog2(MAX_EDGES);
   localparam int CNT_W     = $clog2(MAX_EDGES + 1);

   // fixed field widths
   localparam int VTX_W   = 16;
   localparam int COORD_W = 32;
   localparam int CODE_W  = 16;
   localparam int USED_W  = 11;

   // reverse flag position inside an edge code
   localparam int REV_POS = CODE_W - 1;

   typedef logic [VTX_W-1:0]           vtx_type;
   typedef logic signed [COORD_W-1:0]  coord_type;
   typedef logic [CODE_W-1:0]          code_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      vtx_type   vertex_a;
      vtx_type   vertex_b;
      vtx_type   vertex_c;
      coord_type ax;
      coord_type ay;
      coord_type az;
      coord_type bx;
      coord_type by;
      coord_type bz;
      coord_type cx;
      coord_type cy;
      coord_type cz;
   } req_payload_type;

   typedef struct packed {
      code_type            code_ab;
      code_type            code_bc;
      code_type            code_ca;
      logic                skipped;
      logic                overflow;
      logic [USED_W-1:0]   edges_used;
   } rsp_payload_type;

   // stored edge: start index low, finish index high
   typedef struct packed {
      vtx_type finish;
      vtx_type start;
   } edge_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EDGE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      EDGE_AB,
      EDGE_BC,
      EDGE_CA
   } edge_sel_type;

   // lexicographic x,y,z order, signed coordinates; true if p comes after q
   function automatic logic point_after(point_type p, point_type q);
      logic res;
      if (p.x != q.x) begin
         res = (p.x > q.x);
      end else if (p.y != q.y) begin
         res = (p.y > q.y);
      end else begin
         res = (p.z > q.z);
      end
      return res;
   endfunction

endpackage

/* design/medt_req_if.sv */
interface medt_req_if;
   logic                      valid;
   logic                      ready;
   medt_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* design/medt_rsp_if.sv */
interface medt_rsp_if;
   logic                      valid;
   logic                      ready;
   medt_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* design/mesh_edge_dedup_table.sv */
// mesh edge deduplication table
// req_if carries one triangle per transfer: three vertex indices and the
// signed q16.16 coordinates of each vertex. rsp_if returns one result per
// triangle: the edge codes of ab, bc and ca, the skipped and overflow flags
// and the number of stored edges after the triangle.
// edges are looked up one after another by a single compare unit that walks
// the edge store one slot per cycle, fed by the registered read port of the
// store memory. a miss appends the edge at the fill count, or sets the
// overflow flag when the store is full. a lookup scans the stored edges in
// slot order and stops at the first hit or at the fill count. a degenerate
// triangle skips the lookups and goes straight to the result.
// req_if.ready is high only in the idle state, between items: a new triangle
// is not taken until the result of the last one is loaded into the output
// register.
// the result sits in an output register: the next triangle is taken while it
// waits, and its result is held back until the receiver takes the previous.
// reset empties the store at once by clearing the fill count; there is no
// clearing pass and entries at or above the fill count are never read.
module mesh_edge_dedup_table (
   input logic       clock,
   input logic       reset,
   medt_req_if.sink  req_if,
   medt_rsp_if.source rsp_if
);
   import medt_pkg::*;

   // state
   state_type            state_ff, state_in;
   edge_sel_type         edge_ff;
   req_payload_type      item_ff;
   logic                 skip_ff;
   logic                 overflow_ff;
   code_type             code_ab_ff, code_bc_ff, code_ca_ff;
   logic [CNT_W-1:0]     edge_count_ff;

   // current edge under lookup
   vtx_type              cur_s_ff, cur_f_ff;
   logic                 swap_ff;

   // scan pipeline
   logic [CNT_W-1:0]     issue_ff;
   logic [SLOT_W-1:0]    cmp_idx_ff;
   logic                 pend_ff;
   edge_entry_type       rd_data_ff;

   // result register
   logic                 rsp_valid_ff;
   rsp_payload_type      rsp_data_ff;

   // edge store memory
   edge_entry_type       edge_mem [MAX_EDGES];

   // combinational
   vtx_type              sel_s, sel_f;
   point_type            sel_ps, sel_pf;
   logic                 req_xfer, rsp_free, degenerate;
   logic                 hit_fwd, hit_rev, scan_end, store_full;
   logic                 finish_edge, do_issue, do_insert, do_overflow, load_rsp;
   code_type             edge_code;
   edge_entry_type       new_entry;

   assign req_xfer   = req_if.valid && req_if.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_if.ready;
   assign degenerate = (req_if.data.vertex_a == req_if.data.vertex_b) ||
                       (req_if.data.vertex_a == req_if.data.vertex_c) ||
                       (req_if.data.vertex_b == req_if.data.vertex_c);
   assign store_full = (edge_count_ff == CNT_W'(MAX_EDGES));

   // endpoints of the edge picked by the edge counter
   always_comb begin
      unique case (edge_ff)
         EDGE_AB: begin
            sel_s  = item_ff.vertex_a;
            sel_f  = item_ff.vertex_b;
            sel_ps = '{x: item_ff.ax, y: item_ff.ay, z: item_ff.az};
            sel_pf = '{x: item_ff.bx, y: item_ff.by, z: item_ff.bz};
         end
         EDGE_BC: begin
            sel_s  = item_ff.vertex_b;
            sel_f  = item_ff.vertex_c;
            sel_ps = '{x: item_ff.bx, y: item_ff.by, z: item_ff.bz};
            sel_pf = '{x: item_ff.cx, y: item_ff.cy, z: item_ff.cz};
         end
         default: begin
            sel_s  = item_ff.vertex_c;
            sel_f  = item_ff.vertex_a;
            sel_ps = '{x: item_ff.cx, y: item_ff.cy, z: item_ff.cz};
            sel_pf = '{x: item_ff.ax, y: item_ff.ay, z: item_ff.az};
         end
      endcase
   end

   // shared compare unit: one stored edge per cycle
   assign hit_fwd  = pend_ff && (rd_data_ff.start == cur_s_ff) &&
                     (rd_data_ff.finish == cur_f_ff);
   assign hit_rev  = pend_ff && (rd_data_ff.start == cur_f_ff) &&
                     (rd_data_ff.finish == cur_s_ff);
   assign scan_end = (issue_ff == edge_count_ff);

   // new entry keeps the smaller point first (finish high, start low)
   assign new_entry = swap_ff ? {cur_s_ff, cur_f_ff} : {cur_f_ff, cur_s_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = degenerate ? ST_DONE : ST_EDGE;
            end
         end
         ST_EDGE: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (finish_edge) begin
               state_in = (edge_ff == EDGE_CA) ? ST_DONE : ST_EDGE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_if.ready = (state_ff == ST_IDLE);
      finish_edge  = 1'b0;
      do_issue     = 1'b0;
      do_insert    = 1'b0;
      do_overflow  = 1'b0;
      load_rsp     = 1'b0;
      edge_code    = '0;
      unique case (state_ff)
         ST_SCAN: begin
            finish_edge = hit_fwd || hit_rev || scan_end;
            do_issue    = !finish_edge;
            priority if (hit_fwd) begin
               edge_code = {1'b0, (CODE_W-1)'(cmp_idx_ff)};
            end else if (hit_rev) begin
               edge_code = {1'b1, (CODE_W-1)'(cmp_idx_ff)};
            end else if (scan_end && store_full) begin
               do_overflow = 1'b1;
            end else if (scan_end) begin
               do_insert = 1'b1;
               edge_code = {swap_ff, (CODE_W-1)'(edge_count_ff)};
            end else begin
               // keep scanning
            end
         end
         ST_DONE: begin
            load_rsp = rsp_free;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         edge_count_ff <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_insert) begin
            edge_count_ff <= edge_count_ff + CNT_W'(1);
         end
         if (state_ff == ST_EDGE) begin
            pend_ff <= 1'b0;
         end else if (do_issue) begin
            pend_ff <= 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff     <= req_if.data;
         skip_ff     <= degenerate;
         overflow_ff <= 1'b0;
         edge_ff     <= EDGE_AB;
         code_ab_ff  <= '0;
         code_bc_ff  <= '0;
         code_ca_ff  <= '0;
      end
      if (state_ff == ST_EDGE) begin
         cur_s_ff <= sel_s;
         cur_f_ff <= sel_f;
         swap_ff  <= point_after(sel_ps, sel_pf);
         issue_ff <= '0;
      end
      if (do_issue) begin
         issue_ff   <= issue_ff + CNT_W'(1);
         cmp_idx_ff <= issue_ff[SLOT_W-1:0];
      end
      if (finish_edge) begin
         unique case (edge_ff)
            EDGE_AB: begin
               code_ab_ff <= edge_code;
               edge_ff    <= EDGE_BC;
            end
            EDGE_BC: begin
               code_bc_ff <= edge_code;
               edge_ff    <= EDGE_CA;
            end
            default: begin
               code_ca_ff <= edge_code;
            end
         endcase
      end
      if (do_overflow) begin
         overflow_ff <= 1'b1;
      end
      if (load_rsp) begin
         rsp_data_ff.code_ab    <= code_ab_ff;
         rsp_data_ff.code_bc    <= code_bc_ff;
         rsp_data_ff.code_ca    <= code_ca_ff;
         rsp_data_ff.skipped    <= skip_ff;
         rsp_data_ff.overflow   <= overflow_ff;
         rsp_data_ff.edges_used <= USED_W'(edge_count_ff);
      end
   end

   // edge store: one write and one registered read port
   always_ff @(posedge clock) begin
      if (do_insert) begin
         edge_mem[edge_count_ff[SLOT_W-1:0]] <= new_entry;
      end
      if (do_issue) begin
         rd_data_ff <= edge_mem[issue_ff[SLOT_W-1:0]];
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

`ifndef SYNTHESIS
   // fill count never passes the store depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      edge_count_ff <= CNT_W'(MAX_EDGES))
      else $error("edge count beyond store depth");

   // the store only grows from the scan state
   a_count_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SCAN) |=> $stable(edge_count_ff))
      else $error("edge count changed outside scan");

   // a compared entry was always written before
   a_read_written: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (CNT_W'(cmp_idx_ff) < edge_count_ff))
      else $error("compare of unwritten slot");

   // a skipped triangle reports no overflow and zero edge codes
   a_skip_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.skipped) |->
         (!rsp_data_ff.overflow && rsp_data_ff.code_ab == '0 &&
          rsp_data_ff.code_bc == '0 && rsp_data_ff.code_ca == '0))
      else $error("skipped result carries edge data");
`endif

endmodule
